>>> hdl/tll_pkg.sv
// Shared widths, constants, types and helpers for the taxicab length limiter.
// Used by every module of the block; depends on nothing.
package tll_pkg;

  localparam int COMP_W     = 16;              // component width, signed
  localparam int FRAC_BITS  = 8;               // fraction bits (Q8.8)
  localparam int AXES       = 4;
  localparam int AX_W       = 2;               // axis index width
  localparam int MAG_W      = COMP_W;          // magnitude up to 2^(COMP_W-1)
  localparam int SUM_W      = COMP_W + 2;      // sum of four magnitudes
  localparam int LIMIT_W    = COMP_W + 1;
  localparam int DATA_W     = AXES * COMP_W;
  localparam int TDATA_W    = ((DATA_W + 7) / 8) * 8;

  // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x < 2^SUM_W
  localparam int DIV3_SHIFT = SUM_W + 2;
  localparam int PROD_W     = SUM_W + DIV3_SHIFT;
  localparam logic [DIV3_SHIFT-1:0] DIV3_MUL =
    DIV3_SHIFT'(((65'd1 << DIV3_SHIFT) + 65'd2) / 65'd3);

  localparam logic [LIMIT_W-1:0] LIMIT_ONE = LIMIT_W'(1) << FRAC_BITS;

  typedef logic [COMP_W-1:0] comp_t;
  typedef comp_t [AXES-1:0]  comp_vec_t;
  typedef logic [MAG_W-1:0]  mag_t;
  typedef mag_t [AXES-1:0]   mag_vec_t;
  typedef logic [AX_W-1:0]   axis_t;
  typedef axis_t [AXES-1:0]  axis_vec_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // reduction steps, smallest magnitude first
  localparam axis_t STEP_QUARTER = 2'd0;
  localparam axis_t STEP_THIRD   = 2'd1;
  localparam axis_t STEP_HALF    = 2'd2;
  localparam axis_t STEP_LAST    = 2'd3;

  typedef struct packed {
    mag_vec_t        mag;      // per axis, reduced in place
    logic [AXES-1:0] neg;      // original sign per axis
    axis_vec_t       ord;      // axes by ascending magnitude
    sum_t            excess;   // remaining excess, zero if not limited
    sum_t            share;    // excess/3, filled in ahead of the second step
    logic            limited;
  } work_t;

  function automatic sum_t mag_sum(input mag_vec_t m);
    sum_t s;
    s = '0;
    for (int a = 0; a < AXES; a++) begin
      s = s + SUM_W'(m[a]);
    end
    return s;
  endfunction

endpackage

>>> hdl/taxicab_length_limiter_4d.sv
// Top level of the four-axis taxicab length limiter.
// Instantiates tll_front, tll_step, tll_div3 and tll_back; depends on tll_pkg.
//
//   channel   direction  ports                           contents
//   s_*       in         s_tvalid s_tready s_tdata       x_in, y_in, z_in, w_in
//   m_*       out        m_tvalid m_tready m_tdata/tuser x_out..w_out, was_limited
//   cfg_*     in         cfg_we cfg_wdata                length_limit
//
// One word per cycle sustained while m_tready stays high; eight register
// stages: two front stages (magnitudes, then ranking and excess), the four
// reduction steps with the divide-by-three stage ahead of the second, and the
// output register. Synchronous reset empties every stage and sets the limit
// to 1.0. A stall on m_tready holds each full stage; bubbles still drain
// forward, so s_tready stays high while any stage has room.
module taxicab_length_limiter_4d import tll_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // slave side
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // x_in, y_in, z_in, w_in (16 bits each)
  // master side
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // x_out, y_out, z_out, w_out (16 bits each)
  output logic               m_tuser,   // was_limited
  // configuration
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata  // length_limit, Q9.8
);

  logic [LIMIT_W-1:0] length_limit;

  comp_vec_t in_comp;
  comp_vec_t out_comp;
  logic      out_limited;

  // stage links: front -> step0 -> div3 -> step1 -> step2 -> step3 -> back
  logic  fr_valid, fr_ready;
  work_t fr_work;
  logic  q_valid, q_ready;
  work_t q_work;
  logic  t_valid, t_ready;
  work_t t_work;
  logic  h_valid, h_ready;
  work_t h_work;
  logic  l2_valid, l2_ready;
  work_t l2_work;
  logic  l3_valid, l3_ready;
  work_t l3_work;

  // limit register; to be written only while the pipeline is empty (the user's duty; the block does not enforce it)
  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LIMIT_ONE;
    end else if (cfg_we) begin
      length_limit <= cfg_wdata;
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      in_comp[a] = s_tdata[a*COMP_W +: COMP_W];
    end
  end

  tll_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_comp   (in_comp),
    .limit     (length_limit),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_work  (fr_work)
  );

  // smallest axis takes up to a quarter of the excess
  tll_step u_step_quarter (
    .clk       (clk),
    .rst       (rst),
    .step_idx  (STEP_QUARTER),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_work   (fr_work),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_work  (q_work)
  );

  tll_div3 u_div3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_work   (q_work),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .out_work  (t_work)
  );

  tll_step u_step_third (
    .clk       (clk),
    .rst       (rst),
    .step_idx  (STEP_THIRD),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .in_work   (t_work),
    .out_valid (h_valid),
    .out_ready (h_ready),
    .out_work  (h_work)
  );

  tll_step u_step_half (
    .clk       (clk),
    .rst       (rst),
    .step_idx  (STEP_HALF),
    .in_valid  (h_valid),
    .in_ready  (h_ready),
    .in_work   (h_work),
    .out_valid (l2_valid),
    .out_ready (l2_ready),
    .out_work  (l2_work)
  );

  // largest axis takes whatever excess is left
  tll_step u_step_last (
    .clk       (clk),
    .rst       (rst),
    .step_idx  (STEP_LAST),
    .in_valid  (l2_valid),
    .in_ready  (l2_ready),
    .in_work   (l2_work),
    .out_valid (l3_valid),
    .out_ready (l3_ready),
    .out_work  (l3_work)
  );

  tll_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (l3_valid),
    .in_ready    (l3_ready),
    .in_work     (l3_work),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_comp    (out_comp),
    .out_limited (out_limited)
  );

  assign m_tdata = TDATA_W'(out_comp);
  assign m_tuser = out_limited;

endmodule

>>> hdl/tll_front.sv
// Front of the limiter pipeline: magnitudes and length, then ranking and excess.
// Two register stages; depends on tll_pkg.
module tll_front import tll_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  comp_vec_t            in_comp,
  input  logic [LIMIT_W-1:0]   limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output work_t                out_work
);

  logic            s1_valid;
  mag_vec_t        s1_mag;
  logic [AXES-1:0] s1_neg;
  sum_t            s1_total;
  logic            s1_ready;

  logic            s2_valid;
  work_t           s2_work;
  logic            s2_ready;

  mag_vec_t        abs_mag;
  logic [AXES-1:0] abs_neg;
  axis_vec_t       rank;
  work_t           s2_work_next;

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // stage 1: absolute values
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      abs_neg[a] = in_comp[a][COMP_W-1];
      abs_mag[a] = abs_neg[a] ? mag_t'(-in_comp[a]) : mag_t'(in_comp[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_mag   <= abs_mag;
      s1_neg   <= abs_neg;
      s1_total <= mag_sum(abs_mag);
    end
  end

  // stage 2: rank by magnitude, ties to lower axis; excess over the limit
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rank[a] = '0;
      for (int b = 0; b < AXES; b++) begin
        if ((s1_mag[b] < s1_mag[a]) || ((s1_mag[b] == s1_mag[a]) && (b < a))) begin
          rank[a] = rank[a] + AX_W'(1);
        end
      end
    end
    s2_work_next         = '0;
    s2_work_next.mag     = s1_mag;
    s2_work_next.neg     = s1_neg;
    for (int r = 0; r < AXES; r++) begin
      for (int a = 0; a < AXES; a++) begin
        if (rank[a] == AX_W'(r)) begin
          s2_work_next.ord[r] = AX_W'(a);
        end
      end
    end
    s2_work_next.limited = s1_total > SUM_W'(limit);
    s2_work_next.excess  = s2_work_next.limited ? (s1_total - SUM_W'(limit)) : '0;
    s2_work_next.share   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_work <= s2_work_next;
    end
  end

  assign out_valid = s2_valid;
  assign out_work  = s2_work;

endmodule

>>> hdl/tll_div3.sv
// Pipeline stage that works out a third of the remaining excess by reciprocal.
// Depends on tll_pkg.
module tll_div3 import tll_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_work,
  output logic  out_valid,
  input  logic  out_ready,
  output work_t out_work
);

  logic              valid;
  work_t             work;
  work_t             work_next;
  logic [PROD_W-1:0] prod;

  assign in_ready = !valid || out_ready;

  always_comb begin
    prod            = PROD_W'(in_work.excess) * PROD_W'(DIV3_MUL);
    work_next       = in_work;
    work_next.share = prod[DIV3_SHIFT +: SUM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      work <= work_next;
    end
  end

  assign out_valid = valid;
  assign out_work  = work;

endmodule

>>> hdl/tll_step.sv
// One reduction step: takes a share of the excess off the axis of this rank.
// Register stage, used four times; depends on tll_pkg.
module tll_step import tll_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  axis_t step_idx,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_work,
  output logic  out_valid,
  input  logic  out_ready,
  output work_t out_work
);

  logic  valid;
  work_t work;
  work_t work_next;
  axis_t axis;
  mag_t  mag_cur;
  sum_t  share;
  sum_t  take;

  assign in_ready = !valid || out_ready;

  always_comb begin
    axis = in_work.ord[step_idx];
    case (step_idx)
      STEP_QUARTER: share = in_work.excess >> 2;
      STEP_THIRD:   share = in_work.share;
      STEP_HALF:    share = in_work.excess >> 1;
      default:      share = in_work.excess;
    endcase
    mag_cur = in_work.mag[axis];
    // axis no larger than the share goes to zero, else drops by the share
    take = (SUM_W'(mag_cur) <= share) ? SUM_W'(mag_cur) : share;
    work_next           = in_work;
    work_next.mag[axis] = mag_cur - MAG_W'(take);
    work_next.excess    = in_work.excess - take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      work <= work_next;
    end
  end

  assign out_valid = valid;
  assign out_work  = work;

  a_excess_falls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (work.excess <= $past(in_work.excess)))
    else $error("excess grew across a reduction step");

  a_unlimited_no_excess: assert property (@(posedge clk) disable iff (rst)
    (valid && !work.limited) |-> (work.excess == '0))
    else $error("excess left on a word that was within the limit");

  a_balance: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=>
      ((mag_sum(work.mag) - work.excess) ==
       $past(mag_sum(in_work.mag) - in_work.excess)))
    else $error("magnitude removed differs from excess removed");

endmodule

>>> hdl/tll_back.sv
// Output stage: restores signs and holds the result word for the master side.
// Depends on tll_pkg.
module tll_back import tll_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  work_t     in_work,
  output logic      out_valid,
  input  logic      out_ready,
  output comp_vec_t out_comp,
  output logic      out_limited
);

  logic      valid;
  comp_vec_t comp;
  comp_vec_t comp_next;
  logic      limited;

  assign in_ready = !valid || out_ready;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      comp_next[a] = in_work.neg[a] ? comp_t'(-in_work.mag[a]) : comp_t'(in_work.mag[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      comp    <= comp_next;
      limited <= in_work.limited;
    end
  end

  assign out_valid   = valid;
  assign out_comp    = comp;
  assign out_limited = limited;

endmodule

>>> verif/testbench.sv
// Self-checking bench for taxicab_length_limiter_4d: streams vectors, predicts
// each limited word and compares it with the block's output.
// Depends on tll_pkg and the RTL of the limiter; nothing else.
module testbench import tll_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 200_000; // generous watchdog bound for a correct run
  localparam int WORDS_PER_PHASE  = 175;     // eight random phases, ~1400 words
  localparam int PHASES           = 8;
  localparam int REPORT_LIMIT     = 10;
  localparam int SETTLE_CYCLES    = 12;      // pipeline is 8 deep; a little margin
  localparam int MAX_MAG          = 32768;
  localparam int MAX_TOTAL        = 4 * MAX_MAG;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one predicted output word
  typedef struct {
    comp_vec_t vec;
    logic      limited;
  } clamped_t;

  // Scoreboard: keeps its own copy of length_limit, works out the limited
  // vector when a word goes in, and pops it when a word comes out.
  class taxicab_scoreboard;
    logic [LIMIT_W-1:0] length_limit = LIMIT_ONE;
    clamped_t           due_q[$];
    int                 mismatches = 0;

    // L1 projection, smallest magnitude first, ties to the lower axis
    function clamped_t clamp_l1(comp_vec_t v, logic [LIMIT_W-1:0] lim);
      clamped_t r;
      int comp[AXES];
      int mag[AXES];
      int ord[AXES];
      int total;
      int excess;
      int share;
      int rank;
      int ax;
      total = 0;
      for (int a = 0; a < AXES; a++) begin
        comp[a] = $signed(v[a]);
        mag[a]  = (comp[a] < 0) ? -comp[a] : comp[a];
        total  += mag[a];
      end
      r.limited = (total > int'(lim));
      if (r.limited) begin
        for (int a = 0; a < AXES; a++) begin
          rank = 0;
          for (int b = 0; b < AXES; b++) begin
            if (mag[b] < mag[a] || (mag[b] == mag[a] && b < a)) rank++;
          end
          ord[rank] = a;
        end
        excess = total - int'(lim);
        for (int k = 0; k < AXES; k++) begin
          ax    = ord[k];
          share = excess / (AXES - k);
          if (mag[ax] <= share) begin
            comp[ax] = 0;
            excess  -= mag[ax];
          end else begin
            excess  -= share;
            comp[ax] += (comp[ax] < 0) ? share : -share;
          end
        end
      end
      for (int a = 0; a < AXES; a++) r.vec[a] = comp_t'(comp[a]);
      return r;
    endfunction

    function void note_vector(comp_vec_t v);
      due_q.push_back(clamp_l1(v, length_limit));
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void flag_mismatch(string what, logic [COMP_W-1:0] want,
                                logic [COMP_W-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function void check_output(comp_vec_t v, logic flag);
      clamped_t want;
      string    axis_name[AXES] = '{"x_out", "y_out", "z_out", "w_out"};
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] output word %h/%b with nothing outstanding", $realtime, v, flag);
        return;
      end
      want = due_q.pop_front();
      for (int a = 0; a < AXES; a++) begin
        if (v[a] !== want.vec[a]) flag_mismatch(axis_name[a], want.vec[a], v[a]);
      end
      if (flag !== want.limited)
        flag_mismatch("was_limited", COMP_W'(want.limited), COMP_W'(flag));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block and its surroundings
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  taxicab_length_limiter_4d dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  taxicab_scoreboard  sb = new;
  int                 send_idle_pct = 0;   // chance per cycle that the sender holds back
  int                 stall_pct     = 0;   // chance per cycle that the receiver stalls
  int                 cycle_count   = 0;
  logic [LIMIT_W-1:0] limit_plan [PHASES];

  // receiver: tready changes on the falling edge only
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= stall_pct);
  end

  // both handshakes are observed at the rising edge; inputs were settled at
  // the falling edge before, and the block's own updates land after this
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_vector(s_tdata);
      if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic comp_vec_t pack4(int x, int y, int z, int w);
    comp_vec_t v;
    v[0] = comp_t'(x);
    v[1] = comp_t'(y);
    v[2] = comp_t'(z);
    v[3] = comp_t'(w);
    return v;
  endfunction

  // random sign; a magnitude of 2^15 only exists as a negative component
  function automatic comp_t signed_mag(int m);
    if (m == MAX_MAG || $urandom_range(1) == 1) return comp_t'(-m);
    return comp_t'(m);
  endfunction

  function automatic int random_mag();
    return $urandom_range(0, MAX_MAG) >> $urandom_range(0, 15);
  endfunction

  // mixture of shapes so that every branch of the projection gets exercised
  function automatic comp_vec_t make_vector(logic [LIMIT_W-1:0] lim);
    comp_vec_t v;
    int        kind;
    int        target;
    int        rem;
    int        cap;
    int        m;
    int        start;
    int        tie;
    int        span;
    kind = $urandom_range(9);
    case (kind)
      3, 4: begin
        // small components: little or nothing to take away
        span = 1 << $urandom_range(2, 12);
        for (int a = 0; a < AXES; a++) v[a] = signed_mag($urandom_range(0, span));
      end
      5, 6: begin
        // length just around the limit, so the equal-to-limit edge is hit often
        target = int'(lim) + $urandom_range(0, 6) - 3;
        if (target < 0) target = 0;
        if (target > MAX_TOTAL) target = MAX_TOTAL;
        rem   = target;
        start = $urandom_range(AXES - 1);
        for (int a = 0; a < AXES; a++) begin
          cap = (rem < MAX_MAG) ? rem : MAX_MAG;
          m   = (a == AXES - 1) ? cap : $urandom_range(0, cap);
          rem -= m;
          v[(a + start) % AXES] = signed_mag(m);
        end
      end
      7: begin
        // equal magnitudes on several axes: tie order by axis index
        tie = random_mag();
        for (int a = 0; a < AXES; a++)
          v[a] = ($urandom_range(3) != 0) ? signed_mag(tie) : signed_mag(random_mag());
      end
      8: begin
        // range ends and zeros mixed together
        for (int a = 0; a < AXES; a++) begin
          case ($urandom_range(5))
            0: v[a] = '0;
            1: v[a] = 16'h8000;
            2: v[a] = 16'h7fff;
            3: v[a] = 16'h0001;
            4: v[a] = 16'hffff;
            default: v[a] = comp_t'($urandom);
          endcase
        end
      end
      default: begin
        for (int a = 0; a < AXES; a++) v[a] = comp_t'($urandom);
      end
    endcase
    return v;
  endfunction

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 58; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 58; end
      default:       begin send_idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  // one word on the slave side; entered and left at a falling edge
  task automatic send_word(input comp_vec_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // hold the sender until every outstanding word has come back
  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // register write only on an empty pipeline
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we          = 1'b1;
    cfg_wdata       = value;
    sb.length_limit = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    limit_plan = '{17'd0, 17'd131071, 17'd1, LIMIT_W'($urandom_range(0, 131071)),
                   17'd768, LIMIT_W'($urandom_range(0, 8192)), 17'd40000, LIMIT_ONE};
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed words at the reset limit of 1.0
    set_idling(IDLE_NONE);
    send_word(pack4(0, 0, 0, 0));
    send_word(pack4(256, 0, 0, 0));            // exactly on the limit
    send_word(pack4(0, 0, 0, -256));
    send_word(pack4(257, 0, 0, 0));            // one LSB over
    send_word(pack4(100, -100, 100, -100));    // four-way tie
    send_word(pack4(64, 64, 64, 65));
    send_word(pack4(-32768, -32768, -32768, -32768));
    send_word(pack4(32767, 32767, 32767, 32767));
    send_word(pack4(-32768, 1, 0, 32767));
    send_word(pack4(1, 1, 1, 1));
    send_word(pack4(3, -3, 300, -5));
    send_word(pack4(32767, 0, -32768, 0));
    send_word(pack4(-1, -1, -1, -1));
    send_word(pack4(16'h5555, 16'haaaa, 16'h00ff, 16'hff00));
    send_word(pack4(10, 20, 30, 1000));        // small axes zeroed, rest cut

    // zero limit: anything nonzero collapses to the origin
    write_limit('0);
    send_word(pack4(0, 0, 0, 0));
    send_word(pack4(1, 0, 0, 0));
    send_word(pack4(-5, 7, -9, 11));
    send_word(pack4(-32768, -32768, -32768, -32768));

    // top of the limit range: only four most-negative components exceed it
    write_limit('1);
    send_word(pack4(-32768, -32768, -32768, -32768));
    send_word(pack4(32767, 32767, 32767, 32767));
    send_word(pack4(-32768, -32768, -32768, 32767));

    // random phases, each with its own limit and idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(limit_plan[ph]);
      set_idling(idle_mode_t'(ph % 4));
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        send_word(make_vector(limit_plan[ph]));
        if (ph == 2 && i == WORDS_PER_PHASE / 2) drain();
      end
    end
    s_tvalid = 1'b0;

    // let everything come out, then watch for stray words
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
